/* src/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared widths and codes for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int CELL_W = 16;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd10;

    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef logic [CELL_W-1:0] t_cell;

endpackage

/* src/tcw_cell_ram.sv */
// ----------------------------------------------------------------------------
// tcw_cell_ram
// Single-port cell store: one registered read per cycle, plus a write when i_we is set (the read returns the old data).
// ----------------------------------------------------------------------------
module tcw_cell_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_addr,
    input  tcw_pkg::t_cell      i_wdata,
    output tcw_pkg::t_cell      o_rdata
);

    tcw_pkg::t_cell r_mem [DEPTH];
    tcw_pkg::t_cell r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/tcw_addr_unit.sv */
// ----------------------------------------------------------------------------
// tcw_addr_unit
// Shared cell address unit: row * COLS + column.
// ----------------------------------------------------------------------------
module tcw_addr_unit #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic [$clog2(ROWS)-1:0]      i_row,
    input  logic [$clog2(COLS)-1:0]      i_col,
    output logic [$clog2(ROWS*COLS)-1:0] o_addr
);

    localparam int AW = $clog2(ROWS * COLS);

    assign o_addr = AW'(AW'(i_row) * AW'(COLS)) + AW'(i_col);

endmodule

/* src/text_console_writer.sv */
// ----------------------------------------------------------------------------
// text_console_writer
// Text console: ROWS x COLS grid of 16-bit cells (attribute:char) and a cursor.
//
// Input channel (i_valid / o_stall) carries one command: put a character at
// the cursor, or read one cell. Output channel (o_valid / i_stall) returns one
// result per command: the cell read (0 for a put), the cursor after the
// command and a scroll flag. Configuration (i_cfg_valid / o_cfg_ready) writes
// the attribute byte; it is always ready and should only be written while the
// block is idle.
// After reset the block sweeps all ROWS*COLS cells (2000 by default) of the
// cell store to zero, one cell per cycle, with o_stall held high.
// Steps through the single-port store and the shared address unit:
//   put without scroll: result valid the cycle after the transfer
//   read in range: ST_RD_WAIT for the registered store read, then ST_OUT
//   put that scrolls: ST_SC_RD and ST_SC_WR, one read and one write per moved
//   cell, then ST_FILL, one write per bottom-row cell, before ST_OUT.
// One command is in flight at a time. A result held by i_stall stays in the
// output register and o_stall stays high until it is taken.
// ----------------------------------------------------------------------------
module text_console_writer #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_cmd,
    input  logic [tcw_pkg::CHAR_W-1:0]    i_char_code,
    input  logic [tcw_pkg::ROW_W-1:0]     i_read_row,
    input  logic [tcw_pkg::COL_W-1:0]     i_read_col,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [tcw_pkg::CELL_W-1:0]    o_cell_value,
    output logic [tcw_pkg::ROW_W-1:0]     o_cursor_row,
    output logic [tcw_pkg::COL_W-1:0]     o_cursor_col,
    output logic                          o_scrolled,
    // configuration channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tcw_pkg::ATTR_W-1:0]    i_cfg_data
);

    localparam int RW       = $clog2(ROWS);
    localparam int CW       = $clog2(COLS);
    localparam int AW       = $clog2(ROWS * COLS);
    localparam int ROW_OUTW = tcw_pkg::ROW_W;
    localparam int COL_OUTW = tcw_pkg::COL_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_WAIT,
        ST_SC_RD,
        ST_SC_WR,
        ST_FILL,
        ST_OUT
    } t_state;

    t_state                     r_state;
    logic [RW-1:0]              r_row;
    logic [CW-1:0]              r_col;
    logic [RW-1:0]              r_sw_row;
    logic [CW-1:0]              r_sw_col;
    logic [tcw_pkg::ATTR_W-1:0] r_attr;
    tcw_pkg::t_cell             r_cell;
    logic                       r_scrolled;

    logic [RW-1:0]              au_row;
    logic [CW-1:0]              au_col;
    logic [AW-1:0]              au_addr;
    logic                       ram_we;
    tcw_pkg::t_cell             ram_wdata;
    tcw_pkg::t_cell             ram_rdata;

    logic                       in_xfer;
    logic                       rd_in_range;
    logic                       is_newline;
    logic                       col_last;
    logic                       row_last;
    logic                       sw_col_last;

    assign in_xfer     = i_valid && (r_state == ST_IDLE);
    assign rd_in_range = (int'(i_read_row) < ROWS) && (int'(i_read_col) < COLS);
    assign is_newline  = (i_char_code == tcw_pkg::NEWLINE_CODE);
    assign col_last    = (r_col == CW'(COLS - 1));
    assign row_last    = (r_row == RW'(ROWS - 1));
    assign sw_col_last = (r_sw_col == CW'(COLS - 1));

    // Operand select for the shared address unit and store write port
    always_comb begin
        au_row    = r_sw_row;
        au_col    = r_sw_col;
        ram_we    = 1'b0;
        ram_wdata = {r_attr, i_char_code};
        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
            end
            ST_IDLE: begin
                if (i_cmd == tcw_pkg::CMD_READ) begin
                    au_row = RW'(i_read_row);
                    au_col = CW'(i_read_col);
                end else begin
                    au_row = r_row;
                    au_col = r_col;
                    ram_we = in_xfer && !is_newline;
                end
            end
            ST_SC_RD: begin
                au_row = r_sw_row + RW'(1);
            end
            ST_SC_WR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
            end
            ST_FILL: begin
                au_row    = RW'(ROWS - 1);
                ram_we    = 1'b1;
                ram_wdata = {r_attr, tcw_pkg::SPACE_CODE};
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    tcw_addr_unit #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_addr (
        .i_row  (au_row),
        .i_col  (au_col),
        .o_addr (au_addr)
    );

    tcw_cell_ram #(
        .DEPTH (ROWS * COLS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (au_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_row    <= '0;
            r_col    <= '0;
            r_sw_row <= '0;
            r_sw_col <= '0;
        end else begin
            case (r_state)
                ST_CLEAR: begin
                    if (sw_col_last) begin
                        r_sw_col <= '0;
                        if (r_sw_row == RW'(ROWS - 1)) begin
                            r_sw_row <= '0;
                            r_state  <= ST_IDLE;
                        end else begin
                            r_sw_row <= r_sw_row + RW'(1);
                        end
                    end else begin
                        r_sw_col <= r_sw_col + CW'(1);
                    end
                end
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_scrolled <= 1'b0;
                        r_cell     <= '0;
                        if (i_cmd == tcw_pkg::CMD_READ) begin
                            r_state <= rd_in_range ? ST_RD_WAIT : ST_OUT;
                        end else if (is_newline || col_last) begin
                            r_col <= '0;
                            if (row_last) begin
                                // start the scroll sweep from the top row
                                r_scrolled <= 1'b1;
                                r_sw_row   <= '0;
                                r_sw_col   <= '0;
                                r_state    <= ST_SC_RD;
                            end else begin
                                r_row   <= r_row + RW'(1);
                                r_state <= ST_OUT;
                            end
                        end else begin
                            r_col   <= r_col + CW'(1);
                            r_state <= ST_OUT;
                        end
                    end
                end
                ST_RD_WAIT: begin
                    r_cell  <= ram_rdata;
                    r_state <= ST_OUT;
                end
                ST_SC_RD: begin
                    r_state <= ST_SC_WR;
                end
                ST_SC_WR: begin
                    r_state <= ST_SC_RD;
                    if (sw_col_last) begin
                        r_sw_col <= '0;
                        if (r_sw_row == RW'(ROWS - 2)) begin
                            r_state <= ST_FILL;
                        end else begin
                            r_sw_row <= r_sw_row + RW'(1);
                        end
                    end else begin
                        r_sw_col <= r_sw_col + CW'(1);
                    end
                end
                ST_FILL: begin
                    if (sw_col_last) begin
                        r_sw_col <= '0;
                        r_sw_row <= '0;
                        r_state  <= ST_OUT;
                    end else begin
                        r_sw_col <= r_sw_col + CW'(1);
                    end
                end
                ST_OUT: begin
                    if (!i_stall) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= tcw_pkg::ATTR_RESET;
        end else if (i_cfg_valid) begin
            r_attr <= i_cfg_data;
        end
    end

    assign o_stall      = (r_state != ST_IDLE);
    assign o_valid      = (r_state == ST_OUT);
    assign o_cell_value = r_cell;
    assign o_cursor_row = ROW_OUTW'(r_row);
    assign o_cursor_col = COL_OUTW'(r_col);
    assign o_scrolled   = r_scrolled;
    assign o_cfg_ready  = 1'b1;

    // A pending result blocks new commands
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("command accepted while a result is pending");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_row) < ROWS) && (int'(r_col) < COLS))
        else $error("cursor outside the grid");

    a_scroll_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_scrolled) |-> (r_row == RW'(ROWS - 1)) && (r_col == '0))
        else $error("scroll result without cursor at start of last row");

    a_read_no_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (i_cmd == tcw_pkg::CMD_READ)) |=> $stable(r_row) && $stable(r_col))
        else $error("read command moved the cursor");

endmodule

/* bench/text_console_writer_tb.sv */
// ----------------------------------------------------------------------------
// text_console_writer_tb
// Self-checking bench for the text console writer. A directed table covers
// reset contents, out-of-range reads, byte extremes, newlines and attribute
// changes. Random phases with different attributes and command mixes then
// drive the cursor through line wraps and scrolls. Every result is compared
// with its typed table entry or an in-bench model of the cell grid and cursor.
// ----------------------------------------------------------------------------
module text_console_writer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS         = 80;
    localparam int ROWS         = 25;
    localparam int NCELLS       = ROWS * COLS;
    localparam int MAX_REPORTS  = 10;
    localparam int SETTLE       = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 200;

    localparam int CELL_W = tcw_pkg::CELL_W;
    localparam int CHAR_W = tcw_pkg::CHAR_W;
    localparam int ATTR_W = tcw_pkg::ATTR_W;
    localparam int ROW_W  = tcw_pkg::ROW_W;
    localparam int COL_W  = tcw_pkg::COL_W;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = tcw_pkg::NEWLINE_CODE;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = tcw_pkg::SPACE_CODE;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = tcw_pkg::ATTR_RESET;
    localparam logic              CMD_PUT      = tcw_pkg::CMD_PUT;
    localparam logic              CMD_READ     = tcw_pkg::CMD_READ;

    typedef struct packed {
        tcw_pkg::t_cell   cval;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             scr;
    } t_console_result;

    typedef enum logic {ROW_CMD, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind         kind;
        logic              cmd;
        logic [CHAR_W-1:0] ch;
        logic [ROW_W-1:0]  rr;
        logic [COL_W-1:0]  rc;
        bit                typed;
        t_console_result   res;
    } t_dir_row;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_valid     = 1'b0;
    logic               o_stall;
    logic               i_cmd       = CMD_PUT;
    logic [CHAR_W-1:0]  i_char_code = '0;
    logic [ROW_W-1:0]   i_read_row  = '0;
    logic [COL_W-1:0]   i_read_col  = '0;
    logic               o_valid;
    logic               i_stall     = 1'b1;
    logic [CELL_W-1:0]  o_cell_value;
    logic [ROW_W-1:0]   o_cursor_row;
    logic [COL_W-1:0]   o_cursor_col;
    logic               o_scrolled;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [ATTR_W-1:0]  i_cfg_data  = '0;

    text_console_writer #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_char_code  (i_char_code),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_cell_value (o_cell_value),
        .o_cursor_row (o_cursor_row),
        .o_cursor_col (o_cursor_col),
        .o_scrolled   (o_scrolled),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // console model: grid, cursor and attribute
    tcw_pkg::t_cell     screen_model [NCELLS];
    logic [ROW_W-1:0]   cur_row;
    logic [COL_W-1:0]   cur_col;
    logic [ATTR_W-1:0]  attr_model;

    t_console_result    pending_results [$];
    t_dir_row           dir_table [$];
    int                 mismatch_count = 0;
    bit                 quiet_mode     = 1'b0;
    bit                 hold_off_req   = 1'b0;

    // step to the next row, scrolling the grid when already on the last one
    function automatic logic advance_row();
        int i;
        if (int'(cur_row) == ROWS - 1) begin
            for (i = 0; i < NCELLS - COLS; i++)
                screen_model[i] = screen_model[i + COLS];
            for (i = NCELLS - COLS; i < NCELLS; i++)
                screen_model[i] = {attr_model, SPACE_CODE};
            return 1'b1;
        end
        cur_row = cur_row + 1'b1;
        return 1'b0;
    endfunction

    function automatic t_console_result console_apply(input logic cmd,
                                                      input logic [CHAR_W-1:0] ch,
                                                      input logic [ROW_W-1:0] rr,
                                                      input logic [COL_W-1:0] rc);
        t_console_result r;
        r = '0;
        if (cmd == CMD_READ) begin
            if (int'(rr) < ROWS && int'(rc) < COLS)
                r.cval = screen_model[int'(rr) * COLS + int'(rc)];
        end else if (ch == NEWLINE_CODE) begin
            cur_col = '0;
            r.scr   = advance_row();
        end else begin
            screen_model[int'(cur_row) * COLS + int'(cur_col)] = {attr_model, ch};
            if (int'(cur_col) == COLS - 1) begin
                cur_col = '0;
                r.scr   = advance_row();
            end else begin
                cur_col = cur_col + 1'b1;
            end
        end
        r.row = cur_row;
        r.col = cur_col;
        return r;
    endfunction

    function automatic void add_row(input t_row_kind kind, input logic cmd,
                                    input logic [CHAR_W-1:0] ch,
                                    input logic [ROW_W-1:0] rr,
                                    input logic [COL_W-1:0] rc,
                                    input bit typed = 1'b0,
                                    input tcw_pkg::t_cell cval = '0,
                                    input logic [ROW_W-1:0] row = '0,
                                    input logic [COL_W-1:0] col = '0,
                                    input logic scr = 1'b0);
        t_dir_row d;
        d.kind     = kind;
        d.cmd      = cmd;
        d.ch       = ch;
        d.rr       = rr;
        d.rc       = rc;
        d.typed    = typed;
        d.res.cval = cval;
        d.res.row  = row;
        d.res.col  = col;
        d.res.scr  = scr;
        dir_table.push_back(d);
    endfunction

    task automatic report_mismatch(input string what, input t_console_result want,
                                   input t_console_result got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display({"%0t %s: expected cell=%h row=%0d col=%0d scrolled=%0b, ",
                      "got cell=%h row=%0d col=%0d scrolled=%0b"},
                     $time, what, want.cval, want.row, want.col, want.scr,
                     got.cval, got.row, got.col, got.scr);
    endtask

    // offer one command; hold it until the transfer, then record its result
    task automatic send_item(input logic cmd, input logic [CHAR_W-1:0] ch,
                             input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc,
                             input bit typed, input t_console_result typed_res);
        int gap;
        t_console_result pred;
        gap = quiet_mode ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_cmd       <= cmd;
        i_char_code <= ch;
        i_read_row  <= rr;
        i_read_col  <= rc;
        do @(posedge i_clk); while (o_stall);
        pred = console_apply(cmd, ch, rr, rc);
        pending_results.push_back(typed ? typed_res : pred);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_attr(input logic [ATTR_W-1:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        attr_model   = value;
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin : result_check
        t_console_result got;
        t_console_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            got.cval = o_cell_value;
            got.row  = o_cursor_row;
            got.col  = o_cursor_col;
            got.scr  = o_scrolled;
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", '0, got);
            end else begin
                want = pending_results.pop_front();
                if (got.cval !== want.cval || got.row !== want.row ||
                    got.col !== want.col || got.scr !== want.scr)
                    report_mismatch("result mismatch", want, got);
            end
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin : result_sink
        int n;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                n = quiet_mode ? 0 : $urandom_range(0, 8);
                if (n > 0) begin
                    i_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                end
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin : stimulus
        int i;
        int p;
        int k;
        int roll;
        int sub;
        logic              cmd;
        logic [CHAR_W-1:0] ch;
        logic [ROW_W-1:0]  rr;
        logic [COL_W-1:0]  rc;
        logic [ATTR_W-1:0] phase_attr [PHASES];
        int                read_pct   [PHASES];
        int                nl_pct     [PHASES];

        attr_model = ATTR_RESET;
        cur_row    = '0;
        cur_col    = '0;
        for (i = 0; i < NCELLS; i++)
            screen_model[i] = '0;

        // reset contents and out-of-range reads
        add_row(ROW_CMD, CMD_READ, 8'h00, 5'd0,  7'd0,   1'b1, 16'h0000, 5'd0, 7'd0);
        add_row(ROW_CMD, CMD_READ, 8'h00, 5'd24, 7'd79,  1'b1, 16'h0000, 5'd0, 7'd0);
        add_row(ROW_CMD, CMD_READ, 8'hFF, 5'd31, 7'd127, 1'b1, 16'h0000, 5'd0, 7'd0);
        add_row(ROW_CMD, CMD_READ, 8'h00, 5'd25, 7'd0,   1'b1, 16'h0000, 5'd0, 7'd0);
        add_row(ROW_CMD, CMD_READ, 8'h00, 5'd0,  7'd80,  1'b1, 16'h0000, 5'd0, 7'd0);
        // puts under the reset attribute, high bytes must not sign-extend
        add_row(ROW_CMD, CMD_PUT,  8'h41, 5'd0,  7'd0,   1'b1, 16'h0000, 5'd0, 7'd1);
        add_row(ROW_CMD, CMD_READ, 8'h00, 5'd0,  7'd0,   1'b1, 16'h0A41, 5'd0, 7'd1);
        add_row(ROW_CMD, CMD_PUT,  8'h00, 5'd0,  7'd0);
        add_row(ROW_CMD, CMD_PUT,  8'hFF, 5'd31, 7'd127);
        add_row(ROW_CMD, CMD_PUT,  8'h80, 5'd0,  7'd0);
        add_row(ROW_CMD, CMD_PUT,  NEWLINE_CODE, 5'd0, 7'd0, 1'b1, 16'h0000, 5'd1, 7'd0);
        add_row(ROW_CMD, CMD_READ, 8'h00, 5'd0,  7'd3);
        add_row(ROW_CMD, CMD_READ, 8'h00, 5'd0,  7'd2);
        add_row(ROW_CFG, CMD_PUT,  8'hFF, 5'd0,  7'd0);
        add_row(ROW_CMD, CMD_PUT,  8'h7F, 5'd31, 7'd127);
        add_row(ROW_CMD, CMD_READ, 8'h00, 5'd1,  7'd0);
        add_row(ROW_CFG, CMD_PUT,  8'h00, 5'd0,  7'd0);
        add_row(ROW_CMD, CMD_PUT,  NEWLINE_CODE, 5'd0, 7'd0);
        add_row(ROW_CMD, CMD_PUT,  SPACE_CODE, 5'd0, 7'd0);
        add_row(ROW_CMD, CMD_READ, 8'h00, 5'd2,  7'd0);
        add_row(ROW_CMD, CMD_READ, 8'h00, 5'd0,  7'd1);
        add_row(ROW_CFG, CMD_PUT,  ATTR_RESET, 5'd0, 7'd0);
        add_row(ROW_CMD, CMD_READ, 8'h00, 5'd1,  7'd79);

        phase_attr = '{8'h00, 8'hFF, 8'h80, 8'h00, 8'h00};
        phase_attr[3] = ATTR_W'($urandom_range(0, 255));
        phase_attr[4] = ATTR_W'($urandom_range(0, 255));
        read_pct   = '{40, 10, 40, 30, 50};
        nl_pct     = '{10,  0, 15,  2,  8};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_table[j]) begin
            if (dir_table[j].kind == ROW_CFG)
                write_attr(dir_table[j].ch);
            else
                send_item(dir_table[j].cmd, dir_table[j].ch, dir_table[j].rr,
                          dir_table[j].rc, dir_table[j].typed, dir_table[j].res);
        end

        for (p = 0; p < PHASES; p++) begin
            write_attr(phase_attr[p]);
            quiet_mode = (p == 3);
            // phase 2 opens with a long receiver hold-off against a busy sender
            if (p == 2) begin
                hold_off_req = 1'b1;
                quiet_mode   = 1'b1;
            end
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 2 && k == 20)
                    quiet_mode = 1'b0;
                roll = $urandom_range(0, 99);
                rr   = ROW_W'($urandom);
                rc   = COL_W'($urandom);
                ch   = CHAR_W'($urandom);
                if (roll < read_pct[p]) begin
                    cmd = CMD_READ;
                    sub = $urandom_range(0, 9);
                    // keep most reads in range, half of them near the cursor row; full-width ones reach out of range
                    if (sub >= 2) begin
                        rc = COL_W'($urandom_range(0, COLS - 1));
                        if (sub < 6)
                            rr = (cur_row != 0 && $urandom_range(0, 1)) ? cur_row - 1'b1
                                                                         : cur_row;
                        else
                            rr = ROW_W'($urandom_range(0, ROWS - 1));
                    end
                end else begin
                    cmd = CMD_PUT;
                    if (roll < read_pct[p] + nl_pct[p])
                        ch = NEWLINE_CODE;
                end
                send_item(cmd, ch, rr, rc, 1'b0, '0);
            end
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin : watchdog
        #200ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
